// ===== src/arh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arh_pkg
// Shared constants, register codes and axis codes for the ray/rectangle tester.
// ----------------------------------------------------------------------------
package arh_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int UV_BITS         = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;
	localparam int MAT_W           = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLANE_AXIS   = 3'd0,
		REG_PLANE_OFFSET = 3'd1,
		REG_LOW_A        = 3'd2,
		REG_HIGH_A       = 3'd3,
		REG_LOW_B        = 3'd4,
		REG_HIGH_B       = 3'd5,
		REG_MATERIAL     = 3'd6
	} cfg_reg_t;

	localparam logic [1:0] AXIS_Z = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_X = 2'd2;

endpackage

// ===== src/arh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arh_if
// Valid/ready channels: ray input, hit output, configuration write.
// ----------------------------------------------------------------------------
interface arh_ray_if #(parameter int VW = 32) ();
	logic          valid;
	logic          ready;
	logic [VW-1:0] origin_x, origin_y, origin_z;
	logic [VW-1:0] dir_x, dir_y, dir_z;
	logic [VW-1:0] window_near, window_far;
	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		window_near, window_far, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		window_near, window_far, output ready);
endinterface

interface arh_hit_if #(parameter int VW = 32) ();
	logic                            valid;
	logic                            ready;
	logic                            hit_found;
	logic [VW-1:0]                   ray_distance;
	logic [arh_pkg::UV_BITS:0]       coord_u, coord_v;
	logic [VW-1:0]                   point_x, point_y, point_z;
	logic                            front_face;
	logic [arh_pkg::MAT_W-1:0]       hit_material;
	modport source (output valid, hit_found, ray_distance, coord_u, coord_v, point_x,
		point_y, point_z, front_face, hit_material, input ready);
	modport sink (input valid, hit_found, ray_distance, coord_u, coord_v, point_x,
		point_y, point_z, front_face, hit_material, output ready);
endinterface

interface arh_cfg_if #(parameter int VW = 32) ();
	logic                            valid;
	logic                            ready;
	logic [arh_pkg::CFG_IDX_W-1:0]   index;
	logic [VW-1:0]                   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/arh_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arh_div
// Pipelined restoring divider, one quotient bit per stage. Gives
// min(floor(n * 2^SH / d), cap) with a sideband that rides along.
// ----------------------------------------------------------------------------
module arh_div #(
	parameter int NW = 33,
	parameter int SH = 16,
	parameter int SBW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  logic [NW-1:0]  num,
	input  logic [NW-1:0]  den,
	input  logic [NW:0]    cap,
	input  logic [SBW-1:0] sb_in,
	output logic           out_vld,
	output logic [NW:0]    quo,
	output logic [SBW-1:0] sb_out
);
	// Dividend is num << SH; quotient bits up to NW+SH, capped to NW+1 bits.
	localparam int QW = NW + SH;
	localparam int ST = QW;

	logic                 vld_s [ST+1];
	logic [NW:0]          rem_s [ST+1];
	logic [QW-1:0]        dvd_s [ST+1];
	logic [NW-1:0]        den_s [ST+1];
	logic [NW:0]          cap_s [ST+1];
	logic [SBW-1:0]       sb_s  [ST+1];

	always_comb begin
		vld_s[0] = in_vld;
		rem_s[0] = '0;
		dvd_s[0] = {num, {SH{1'b0}}};
		den_s[0] = den;
		cap_s[0] = cap;
		sb_s[0]  = sb_in;
	end

	for (genvar i = 0; i < ST; i++) begin : g_st
		logic [NW+1:0] sh_w;
		logic [NW+1:0] sub_w;
		assign sh_w  = {rem_s[i], dvd_s[i][QW-1]};
		assign sub_w = sh_w - {2'b00, den_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= sub_w[NW+1] ? sh_w[NW:0] : sub_w[NW:0];
				dvd_s[i+1] <= {dvd_s[i][QW-2:0], ~sub_w[NW+1]};
				den_s[i+1] <= den_s[i];
				cap_s[i+1] <= cap_s[i];
				sb_s[i+1]  <= sb_s[i];
			end
		end
	end

	// Dividend bits were shifted out as quotient bits shifted in.
	logic [QW-1:0] qf;
	assign qf = dvd_s[ST];
	assign out_vld = vld_s[ST];
	assign quo = ({{(NW+1){1'b0}}, qf} > {{QW{1'b0}}, cap_s[ST]}) ?
		cap_s[ST] : qf[NW:0];
	assign sb_out = sb_s[ST];
endmodule

// ===== src/arh_fmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arh_fmul
// Signed fixed-point product (a*b)>>FB, truncated toward zero, magnitude
// capped at 2^VW. Combinational; caller registers the result.
// ----------------------------------------------------------------------------
module arh_fmul #(
	parameter int VW = 32,
	parameter int FB = 16
) (
	input  logic [VW-1:0] a,
	input  logic [VW-1:0] b,
	output logic [VW+1:0] p
);
	logic [VW-1:0]   ma, mb;
	logic [2*VW-1:0] pr;
	logic [2*VW-1:0] sh;
	logic [VW:0]     m;
	logic            ng;
	always_comb begin
		ma = a[VW-1] ? (~a + 1'b1) : a;
		mb = b[VW-1] ? (~b + 1'b1) : b;
		pr = ma * mb;
		sh = pr >> FB;
		m = (sh > {{(VW-1){1'b0}}, 1'b1, {VW{1'b0}}}) ? {1'b1, {VW{1'b0}}} : sh[VW:0];
		ng = a[VW-1] ^ b[VW-1];
		p = ng ? (~{1'b0, m} + 1'b1) : {1'b0, m};
	end
endmodule

// ===== src/axis_rect_ray_hit.sv =====
`timescale 1ns / 1ps
// Pipeline: setup, t divider, window, products, bounds,
//   normalize dividers (u and v side by side), output register.
// Throughput: one ray per cycle; the whole pipe advances while the output
//   register is empty or being taken, so a stall holds every stage.
// Reset: arst_n clears all valid bits and loads register defaults
//   (high_a = high_b = 1.0, others 0). No clearing pass.
// ----------------------------------------------------------------------------
// axis_rect_ray_hit
// Ray vs axis-aligned rectangle tester, deep pipeline with one-bit-per-stage dividers.
// ----------------------------------------------------------------------------
module axis_rect_ray_hit #(
	parameter int FRAC_BITS   = arh_pkg::FRAC_BITS_DEF,
	parameter int VALUE_WIDTH = arh_pkg::VALUE_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	arh_ray_if.sink   ray,
	arh_hit_if.source hit,
	arh_cfg_if.sink   cfg
);
	localparam int VW = VALUE_WIDTH;
	localparam int UW = arh_pkg::UV_BITS;
	localparam int MW = arh_pkg::MAT_W;

	// ---------------- configuration registers ----------------
	logic [1:0]    plane_axis_q;
	logic [VW-1:0] plane_offset_q, low_a_q, high_a_q, low_b_q, high_b_q;
	logic [MW-1:0] material_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_axis_q   <= '0;
			plane_offset_q <= '0;
			low_a_q        <= '0;
			high_a_q       <= VW'(1) << FRAC_BITS;
			low_b_q        <= '0;
			high_b_q       <= VW'(1) << FRAC_BITS;
			material_q     <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				arh_pkg::REG_PLANE_AXIS:   plane_axis_q   <= cfg.data[1:0];
				arh_pkg::REG_PLANE_OFFSET: plane_offset_q <= cfg.data;
				arh_pkg::REG_LOW_A:        low_a_q        <= cfg.data;
				arh_pkg::REG_HIGH_A:       high_a_q       <= cfg.data;
				arh_pkg::REG_LOW_B:        low_b_q        <= cfg.data;
				arh_pkg::REG_HIGH_B:       high_b_q       <= cfg.data;
				arh_pkg::REG_MATERIAL:     material_q     <= cfg.data[MW-1:0];
				default: ;
			endcase
		end
	end

	// Global advance: everything moves unless output holds a result not taken.
	logic en;
	assign en = !hit.valid || hit.ready;
	assign ray.ready = en;

	// ---------------- s1: select axes, form numerator ----------------
	logic          v_s1, ok_s1, neg_s1, ff_s1;
	logic [VW-1:0] o_s1 [3];
	logic [VW-1:0] d_s1 [3];
	logic [VW-1:0] near_s1, far_s1;
	logic [VW:0]   num_mag_s1;
	logic [VW-1:0] den_mag_s1;
	logic [1:0]    ax_s1;

	logic [VW-1:0] on_w, dn_w;
	logic [VW:0]   num_w;
	always_comb begin
		case (plane_axis_q)
			arh_pkg::AXIS_Z: begin on_w = ray.origin_z; dn_w = ray.dir_z; end
			arh_pkg::AXIS_Y: begin on_w = ray.origin_y; dn_w = ray.dir_y; end
			arh_pkg::AXIS_X: begin on_w = ray.origin_x; dn_w = ray.dir_x; end
			default:         begin on_w = ray.origin_x; dn_w = ray.dir_x; end
		endcase
		num_w = {plane_offset_q[VW-1], plane_offset_q} - {on_w[VW-1], on_w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= ray.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			o_s1[0] <= ray.origin_x; o_s1[1] <= ray.origin_y; o_s1[2] <= ray.origin_z;
			d_s1[0] <= ray.dir_x;    d_s1[1] <= ray.dir_y;    d_s1[2] <= ray.dir_z;
			near_s1 <= ray.window_near;
			far_s1  <= ray.window_far;
			ok_s1   <= (plane_axis_q != 2'd3) && (dn_w != '0);
			neg_s1  <= num_w[VW] ^ dn_w[VW-1];
			ff_s1   <= dn_w[VW-1];
			num_mag_s1 <= num_w[VW] ? (~num_w + 1'b1) : num_w;
			den_mag_s1 <= dn_w[VW-1] ? (~dn_w + 1'b1) : dn_w;
			ax_s1   <= plane_axis_q;
		end
	end

	// ---------------- t divider ----------------
	// Sideband carries the whole ray; unpacked at the far end.
	localparam int SBW = 6*VW + 2*VW + 5;
	logic [SBW-1:0] sb_in, sb_out;
	logic [VW+1:0]  tq;
	logic           tdv;
	logic [VW+1:0]  tcap;
	assign sb_in = {o_s1[0], o_s1[1], o_s1[2], d_s1[0], d_s1[1], d_s1[2],
		near_s1, far_s1, ok_s1, neg_s1, ff_s1, ax_s1};
	assign tcap = neg_s1 ? {2'b00, 1'b1, {(VW-1){1'b0}}} : {3'b000, {(VW-1){1'b1}}};
	arh_div #(.NW(VW+1), .SH(FRAC_BITS), .SBW(SBW)) u_tdiv (
		.clk, .arst_n, .en, .in_vld(v_s1), .num(num_mag_s1),
		.den({1'b0, den_mag_s1}), .cap(tcap), .sb_in, .out_vld(tdv), .quo(tq),
		.sb_out
	);

	// ---------------- s2: sign t, window test ----------------
	logic [VW-1:0] ox_w, oy_w, oz_w, dx_w, dy_w, dz_w, nr_w, fr_w;
	logic          ok_w, ng_w, ff_w;
	logic [1:0]    ax_w;
	assign {ox_w, oy_w, oz_w, dx_w, dy_w, dz_w, nr_w, fr_w, ok_w, ng_w, ff_w, ax_w} = sb_out;
	logic [VW-1:0] t_w;
	assign t_w = ng_w ? (~tq[VW-1:0] + 1'b1) : tq[VW-1:0];

	logic          v_s2, ok_s2, ff_s2;
	logic [VW-1:0] t_s2;
	logic [VW-1:0] o_s2 [3];
	logic [VW-1:0] d_s2 [3];
	logic [1:0]    ax_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= tdv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2  <= t_w;
			ok_s2 <= ok_w && !($signed(t_w) < $signed(nr_w)) && !($signed(t_w) > $signed(fr_w));
			ff_s2 <= ff_w;
			ax_s2 <= ax_w;
			o_s2[0] <= ox_w; o_s2[1] <= oy_w; o_s2[2] <= oz_w;
			d_s2[0] <= dx_w; d_s2[1] <= dy_w; d_s2[2] <= dz_w;
		end
	end

	// ---------------- s3: products ----------------
	logic [VW+1:0] p_w [3];
	for (genvar k = 0; k < 3; k++) begin : g_mul
		arh_fmul #(.VW(VW), .FB(FRAC_BITS)) u_mul (.a(t_s2), .b(d_s2[k]), .p(p_w[k]));
	end
	logic          v_s3, ok_s3, ff_s3;
	logic [VW-1:0] t_s3;
	logic [VW-1:0] o_s3 [3];
	logic [VW+1:0] p_s3 [3];
	logic [1:0]    ax_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3 <= ok_s2; ff_s3 <= ff_s2; t_s3 <= t_s2; ax_s3 <= ax_s2;
			for (int k = 0; k < 3; k++) begin
				o_s3[k] <= o_s2[k];
				p_s3[k] <= p_w[k];
			end
		end
	end

	// ---------------- s4: sums, bounds, saturate ----------------
	logic [VW+2:0] c_w [3];
	logic [VW-1:0] pt_w [3];
	logic [VW+2:0] ca_w, cb_w;
	logic          inb_w;
	localparam logic [VW+2:0] VMAXE = {4'b0000, {(VW-1){1'b1}}};
	localparam logic [VW+2:0] VMINE = {4'b1111, {(VW-1){1'b0}}};
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c_w[k] = {{3{o_s3[k][VW-1]}}, o_s3[k]} + {p_s3[k][VW+1], p_s3[k]};
			if ($signed(c_w[k]) > $signed(VMAXE)) pt_w[k] = VMAXE[VW-1:0];
			else if ($signed(c_w[k]) < $signed(VMINE)) pt_w[k] = VMINE[VW-1:0];
			else pt_w[k] = c_w[k][VW-1:0];
		end
		case (ax_s3)
			arh_pkg::AXIS_Z: begin ca_w = c_w[0]; cb_w = c_w[1]; end
			arh_pkg::AXIS_Y: begin ca_w = c_w[0]; cb_w = c_w[2]; end
			default:         begin ca_w = c_w[1]; cb_w = c_w[2]; end
		endcase
		inb_w = !($signed(ca_w) < $signed({{3{low_a_q[VW-1]}}, low_a_q}))
			&& !($signed(ca_w) > $signed({{3{high_a_q[VW-1]}}, high_a_q}))
			&& !($signed(cb_w) < $signed({{3{low_b_q[VW-1]}}, low_b_q}))
			&& !($signed(cb_w) > $signed({{3{high_b_q[VW-1]}}, high_b_q}));
	end

	// Offsets from low bound and spans fit VW+1 bits unsigned once in bounds.
	logic          v_s4, hit_s4, ff_s4;
	logic [VW-1:0] t_s4;
	logic [VW-1:0] pt_s4 [3];
	logic [VW:0]   ua_s4, sa_s4, ub_s4, sb_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= ok_s3 && inb_w;
			ff_s4  <= ff_s3;
			t_s4   <= t_s3;
			for (int k = 0; k < 3; k++) pt_s4[k] <= pt_w[k];
			ua_s4 <= ca_w[VW:0] - {low_a_q[VW-1], low_a_q};
			sa_s4 <= {high_a_q[VW-1], high_a_q} - {low_a_q[VW-1], low_a_q};
			ub_s4 <= cb_w[VW:0] - {low_b_q[VW-1], low_b_q};
			sb_s4 <= {high_b_q[VW-1], high_b_q} - {low_b_q[VW-1], low_b_q};
		end
	end

	// ---------------- normalize: two dividers in parallel ----------------
	localparam int SB2 = 1 + 1 + VW + 3*VW + 2;
	logic [SB2-1:0] sb2_in, sb2_out, sbb_unused;
	logic [VW+1:0]  uq, vq;
	logic           uv_vld, vb_vld;
	logic [VW+1:0]  uvcap;
	assign uvcap = {{(VW+1-UW){1'b0}}, 1'b1, {UW{1'b0}}};
	assign sb2_in = {hit_s4, ff_s4, t_s4, pt_s4[0], pt_s4[1], pt_s4[2],
		(sa_s4 == '0), (sb_s4 == '0)};
	arh_div #(.NW(VW+1), .SH(UW), .SBW(SB2)) u_udiv (
		.clk, .arst_n, .en, .in_vld(v_s4), .num(ua_s4),
		.den((sa_s4 == '0) ? {{VW{1'b0}}, 1'b1} : sa_s4), .cap(uvcap),
		.sb_in(sb2_in), .out_vld(uv_vld), .quo(uq), .sb_out(sb2_out)
	);
	arh_div #(.NW(VW+1), .SH(UW), .SBW(SB2)) u_vdiv (
		.clk, .arst_n, .en, .in_vld(v_s4), .num(ub_s4),
		.den((sb_s4 == '0) ? {{VW{1'b0}}, 1'b1} : sb_s4), .cap(uvcap),
		.sb_in(sb2_in), .out_vld(vb_vld), .quo(vq), .sb_out(sbb_unused)
	);

	logic          h_w, f_w, za_w, zb_w;
	logic [VW-1:0] tt_w, px_w, py_w, pz_w;
	assign {h_w, f_w, tt_w, px_w, py_w, pz_w, za_w, zb_w} = sb2_out;

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hit.valid <= 1'b0;
		else if (en) hit.valid <= uv_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hit.hit_found    <= h_w;
			hit.ray_distance <= h_w ? tt_w : '0;
			hit.coord_u      <= (h_w && !za_w) ? uq[UW:0] : '0;
			hit.coord_v      <= (h_w && !zb_w && vb_vld) ? vq[UW:0] : '0;
			hit.point_x      <= h_w ? px_w : '0;
			hit.point_y      <= h_w ? py_w : '0;
			hit.point_z      <= h_w ? pz_w : '0;
			hit.front_face   <= h_w && f_w;
			hit.hit_material <= h_w ? material_q : '0;
		end
	end

	// ---------------- assertions ----------------
	a_uv_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		uv_vld == vb_vld) else $error("normalize dividers out of step");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hit.valid && !hit.ready |=> hit.valid && $stable(hit.ray_distance))
		else $error("result changed under stall");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hit.valid && !hit.hit_found |-> hit.ray_distance == '0 && !hit.front_face)
		else $error("miss carries data");
	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		hit.valid |-> hit.coord_u <= (UW+1)'(1 << UW) && hit.coord_v <= (UW+1)'(1 << UW))
		else $error("normalized coordinate out of range");
endmodule

// ===== bench/tb_axis_rect_ray_hit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_rect_ray_hit
// Self-checking bench for the ray vs axis-aligned rectangle tester. A directed
// table runs first under reset settings, then random rays under those and several
// others, each result compared field by field with a table entry or a predictor.
// ----------------------------------------------------------------------------
module tb_axis_rect_ray_hit;

	localparam int  VW      = 32;
	localparam int  FB      = 16;
	localparam longint ONE  = 64'sd65536;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;

	typedef struct {
		logic signed [VW-1:0] ox, oy, oz, dx, dy, dz, wn, wf;
	} ray_t;

	typedef struct {
		logic          found;
		logic [VW-1:0] rdist;
		logic [16:0]   u, v;
		logic [VW-1:0] px, py, pz;
		logic          front;
		logic [15:0]   mat;
	} hit_t;

	typedef struct {
		ray_t r;
		bit   typed;
		hit_t e;
	} row_t;

	logic clk;
	logic arst_n;

	arh_ray_if #(VW) ray_ch ();
	arh_hit_if #(VW) hit_ch ();
	arh_cfg_if #(VW) cfg_ch ();

	axis_rect_ray_hit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.ray   (ray_ch),
		.hit   (hit_ch),
		.cfg   (cfg_ch)
	);

	// rectangle settings as the bench believes them to be
	logic [1:0]  rect_axis;
	longint      rect_off, rect_la, rect_ha, rect_lb, rect_hb;
	logic [15:0] rect_mat;

	hit_t   hits_due[$];
	int     n_bad;
	int     n_rays;
	int     n_hits;
	int     n_seen;
	bit     quiet;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop, far beyond any correct run
	initial begin
		#(20 * 400000);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic longint mag64(longint x);
		return x < 0 ? -x : x;
	endfunction

	// (a * b) >> FB toward zero, magnitude clamped at 2^32
	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] p;
		longint       m;
		p = (128'(mag64(a)) * 128'(mag64(b))) >> FB;
		m = (p > 128'h1_0000_0000) ? 64'sh1_0000_0000 : longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic longint clamp32(longint x);
		return x > VMAX ? VMAX : (x < VMIN ? VMIN : x);
	endfunction

	// normalized coordinate, 16 fraction bits, capped at 1.0
	function automatic logic [16:0] unit_coord(longint x, longint lo, longint hi);
		logic [127:0] q;
		if (hi == lo) return 17'd0;
		q = (128'(x - lo) << 16) / 128'(hi - lo);
		return q > 128'd65536 ? 17'd65536 : q[16:0];
	endfunction

	function automatic hit_t trace_ray(ray_t r);
		hit_t         h;
		longint       o[3], d[3], c[3];
		longint       num, t, ca, cb;
		logic [127:0] q;
		longint       cap;
		int           n, a, b;
		bit           neg;
		h = '{default: '0};
		o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
		d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
		case (rect_axis)
			arh_pkg::AXIS_Z:  begin n = 2; a = 0; b = 1; end
			arh_pkg::AXIS_Y:  begin n = 1; a = 0; b = 2; end
			arh_pkg::AXIS_X:  begin n = 0; a = 1; b = 2; end
			default: return h;
		endcase
		if (d[n] == 0) return h;
		num = rect_off - o[n];
		neg = (num < 0) != (d[n] < 0);
		cap = neg ? 64'sd2147483648 : VMAX;
		q = (128'(mag64(num)) << FB) / 128'(mag64(d[n]));
		t = (q > 128'(cap)) ? cap : longint'(q[63:0]);
		if (neg) t = -t;
		if (t < longint'(r.wn) || t > longint'(r.wf)) return h;
		ca = o[a] + fx_mul(t, d[a]);
		cb = o[b] + fx_mul(t, d[b]);
		if (ca < rect_la || ca > rect_ha || cb < rect_lb || cb > rect_hb) return h;
		for (int i = 0; i < 3; i++) c[i] = clamp32(o[i] + fx_mul(t, d[i]));
		h.found = 1'b1;
		h.rdist = t[VW-1:0];
		h.u     = unit_coord(ca, rect_la, rect_ha);
		h.v     = unit_coord(cb, rect_lb, rect_hb);
		h.px    = c[0][VW-1:0];
		h.py    = c[1][VW-1:0];
		h.pz    = c[2][VW-1:0];
		h.front = d[n] < 0;
		h.mat   = rect_mat;
		return h;
	endfunction

	// output side: random back-pressure, none during the quiet stretch
	always @(negedge clk) begin
		if (arst_n) hit_ch.ready <= quiet || ($urandom % 100 >= 21);
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		hit_t e;
		if (arst_n && hit_ch.valid && hit_ch.ready) begin
			n_seen++;
			if (hits_due.size() == 0) begin
				$error("result transfer with nothing expected");
				n_bad++;
			end else begin
				e = hits_due.pop_front();
				if (hit_ch.hit_found !== e.found) begin
					$error("hit_found exp %0d got %0d", e.found, hit_ch.hit_found); n_bad++;
				end
				if (hit_ch.ray_distance !== e.rdist) begin
					$error("ray_distance exp %h got %h", e.rdist, hit_ch.ray_distance); n_bad++;
				end
				if (hit_ch.coord_u !== e.u) begin
					$error("coord_u exp %h got %h", e.u, hit_ch.coord_u); n_bad++;
				end
				if (hit_ch.coord_v !== e.v) begin
					$error("coord_v exp %h got %h", e.v, hit_ch.coord_v); n_bad++;
				end
				if (hit_ch.point_x !== e.px) begin
					$error("point_x exp %h got %h", e.px, hit_ch.point_x); n_bad++;
				end
				if (hit_ch.point_y !== e.py) begin
					$error("point_y exp %h got %h", e.py, hit_ch.point_y); n_bad++;
				end
				if (hit_ch.point_z !== e.pz) begin
					$error("point_z exp %h got %h", e.pz, hit_ch.point_z); n_bad++;
				end
				if (hit_ch.front_face !== e.front) begin
					$error("front_face exp %0d got %0d", e.front, hit_ch.front_face); n_bad++;
				end
				if (hit_ch.hit_material !== e.mat) begin
					$error("hit_material exp %h got %h", e.mat, hit_ch.hit_material); n_bad++;
				end
			end
		end
	end

	// one ray transfer; called and returns at a falling edge
	task automatic send_ray(ray_t r, bit has_exp, hit_t e);
		while (!quiet && ($urandom % 100 < 21)) begin
			ray_ch.valid <= 1'b0;
			@(negedge clk);
		end
		ray_ch.valid       <= 1'b1;
		ray_ch.origin_x    <= r.ox;
		ray_ch.origin_y    <= r.oy;
		ray_ch.origin_z    <= r.oz;
		ray_ch.dir_x       <= r.dx;
		ray_ch.dir_y       <= r.dy;
		ray_ch.dir_z       <= r.dz;
		ray_ch.window_near <= r.wn;
		ray_ch.window_far  <= r.wf;
		@(posedge clk);
		while (!ray_ch.ready) @(posedge clk);
		hits_due.push_back(has_exp ? e : trace_ray(r));
		if (hits_due[$].found) n_hits++;
		n_rays++;
		@(negedge clk);
	endtask

	// leaves valid high so writes can run back to back; caller drops it
	task automatic write_reg(arh_pkg::cfg_reg_t idx, logic [VW-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			arh_pkg::REG_PLANE_AXIS:   rect_axis = val[1:0];
			arh_pkg::REG_PLANE_OFFSET: rect_off  = longint'(signed'(val));
			arh_pkg::REG_LOW_A:        rect_la   = longint'(signed'(val));
			arh_pkg::REG_HIGH_A:       rect_ha   = longint'(signed'(val));
			arh_pkg::REG_LOW_B:        rect_lb   = longint'(signed'(val));
			arh_pkg::REG_HIGH_B:       rect_hb   = longint'(signed'(val));
			arh_pkg::REG_MATERIAL:     rect_mat  = val[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain;
		ray_ch.valid <= 1'b0;
		while (hits_due.size() != 0) @(negedge clk);
	endtask

	function automatic longint rand_span(longint span);
		logic [63:0] w;
		w = {32'($urandom), 32'($urandom)};
		w[63] = 1'b0;
		return longint'(w % 64'(span + 1));
	endfunction

	// mostly rays aimed at the rectangle, the rest raw noise
	function automatic ray_t make_ray();
		ray_t   r;
		longint d[3], p[3], o[3], t;
		int     n, a, b;
		r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
		r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
		r.wn = $urandom; r.wf = $urandom;
		if ($urandom % 100 < 15 || rect_axis > arh_pkg::AXIS_X) begin
			if ($urandom % 2) begin
				r.wn = 32'(VMIN);
				r.wf = 32'(VMAX);
			end
			return r;
		end
		case (rect_axis)
			arh_pkg::AXIS_Z:  begin n = 2; a = 0; b = 1; end
			arh_pkg::AXIS_Y:  begin n = 1; a = 0; b = 2; end
			default: begin n = 0; a = 1; b = 2; end
		endcase
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'($urandom_range(0, 8 * 65536)) - 4 * ONE;
			if ($urandom % 8 == 0) d[i] = 0;
		end
		if ($urandom % 30 == 0) d[n] = 0;
		t = longint'($urandom_range(0, 16 * 65536));
		if ($urandom % 8 == 0) t = -t;
		p[n] = rect_off;
		p[a] = (rect_ha >= rect_la) ? rect_la + rand_span(rect_ha - rect_la)
			: rect_ha + rand_span(rect_la - rect_ha);
		p[b] = (rect_hb >= rect_lb) ? rect_lb + rand_span(rect_hb - rect_lb)
			: rect_hb + rand_span(rect_lb - rect_hb);
		if ($urandom % 10 == 0) p[a] = p[a] + longint'($urandom_range(0, 4 * 65536)) - 2 * ONE;
		for (int i = 0; i < 3; i++) o[i] = p[i] - fx_mul(t, d[i]);
		r.ox = o[0][31:0]; r.oy = o[1][31:0]; r.oz = o[2][31:0];
		r.dx = d[0][31:0]; r.dy = d[1][31:0]; r.dz = d[2][31:0];
		r.wn = 32'(clamp32(t - longint'($urandom_range(0, 65536))));
		r.wf = 32'(clamp32(t + longint'($urandom_range(0, 65536))));
		if ($urandom % 12 == 0) begin
			r.wn = 32'(clamp32(t + 1));
			r.wf = 32'(clamp32(t - 1));
		end
		return r;
	endfunction

	hit_t no_hit;
	hit_t h_mid, h_low, h_top;
	row_t plan[$];

	// rectangle settings per phase: axis, offset, low_a, high_a, low_b, high_b, material
	logic [31:0] phase_regs[6][7] = '{
		'{32'd1, 32'h0002_0000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h1234},
		'{32'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF},
		'{32'd0, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0004_0000, 32'h0},
		'{32'd3, 32'h0, 32'hFFFE_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0002_0000, 32'hA5A5},
		'{32'd0, 32'hFFFD_0000, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h00FF},
		'{32'd1, 32'hFFFF_8000, 32'hFFF0_0000, 32'h0010_0000, 32'hFFFC_0000, 32'h0008_0000, 32'h7E01}
	};

	initial begin
		int guard;
		n_bad = 0; n_rays = 0; n_hits = 0; n_seen = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		ray_ch.valid = 1'b0;
		ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
		ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
		ray_ch.window_near = '0; ray_ch.window_far = '0;
		hit_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = arh_pkg::REG_PLANE_AXIS;
		cfg_ch.data = '0;
		rect_axis = arh_pkg::AXIS_Z; rect_off = 0;
		rect_la = 0; rect_ha = ONE; rect_lb = 0; rect_hb = ONE;
		rect_mat = '0;

		// results readable straight off the reset rectangle (unit square at z=0)
		no_hit = '{default: '0};
		h_mid = '{1'b1, 32'h0001_0000, 17'h08000, 17'h08000,
			32'h0000_8000, 32'h0000_8000, 32'h0, 1'b1, 16'h0};
		h_low = '{1'b1, 32'h0001_0000, 17'h0, 17'h0, 32'h0, 32'h0, 32'h0, 1'b1, 16'h0};
		h_top = '{1'b1, 32'h0001_0000, 17'h10000, 17'h10000,
			32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0, 16'h0};

		// center hit from above
		plan.push_back('{'{32'h8000, 32'h8000, 32'h10000, 0, 0, 32'hFFFF_0000, 0, 32'h20000},
			1, h_mid});
		// zero direction along the normal
		plan.push_back('{'{32'h8000, 32'h8000, 32'h10000, 32'h10000, 0, 0, 0, 32'h20000},
			1, no_hit});
		// inverted window
		plan.push_back('{'{32'h8000, 32'h8000, 32'h10000, 0, 0, 32'hFFFF_0000, 32'h20000, 0},
			1, no_hit});
		// window just short of t
		plan.push_back('{'{32'h8000, 32'h8000, 32'h10000, 0, 0, 32'hFFFF_0000, 0, 32'hFFFF},
			1, no_hit});
		// low corner, bounds inclusive
		plan.push_back('{'{0, 0, 32'h10000, 0, 0, 32'hFFFF_0000, 32'h10000, 32'h10000},
			1, h_low});
		// high corner from below, back face
		plan.push_back('{'{32'h10000, 32'h10000, 32'hFFFF_0000, 0, 0, 32'h10000, 0, 32'h10000},
			1, h_top});
		// just outside the high edge
		plan.push_back('{'{32'h10001, 32'h8000, 32'h10000, 0, 0, 32'hFFFF_0000, 0, 32'h20000},
			1, no_hit});
		// field extremes, all-zero and all-one rays, saturated t
		plan.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, no_hit});
		plan.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, no_hit});
		plan.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0, no_hit});
		plan.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 0, no_hit});
		plan.push_back('{'{32'h8000, 32'h8000, 32'h8000_0000, 0, 0, 32'h1,
			32'h8000_0000, 32'h7FFF_FFFF}, 0, no_hit});
		plan.push_back('{'{32'h8000, 32'h8000, 32'h7FFF_FFFF, 0, 0, 32'h1,
			32'h8000_0000, 32'h7FFF_FFFF}, 0, no_hit});
		plan.push_back('{'{32'h8000, 32'h8000, 32'h10000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0, no_hit});
		plan.push_back('{'{32'hC000, 32'h4000, 32'h30000, 32'h1000, 32'hFFFF_F000,
			32'hFFFD_0000, 32'h0, 32'h7FFF_FFFF}, 0, no_hit});

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) send_ray(plan[i].r, plan[i].typed, plan[i].typed ? plan[i].e : no_hit);
		for (int k = 0; k < 150; k++) send_ray(make_ray(), 0, no_hit);

		// walk the rectangle settings; only reconfigure once the pipe is empty
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			for (int k = 0; k < 7; k++)
				write_reg(arh_pkg::cfg_reg_t'(k), phase_regs[ph][k]);
			cfg_ch.valid <= 1'b0;
			for (int k = 0; k < 210; k++) begin
				quiet = (ph == 5) && (k >= 40) && (k < 140);
				send_ray(make_ray(), 0, no_hit);
			end
			quiet = 1'b0;
		end

		drain();
		guard = 0;
		while (hits_due.size() != 0 && guard < 10000) begin
			@(negedge clk);
			guard++;
		end
		repeat (80) @(negedge clk);

		$display("covered %0d rays across 7 rectangle settings, %0d of them hits",
			n_rays, n_hits);
		$display("%0d results checked, %0d field mismatches", n_seen, n_bad);
		if (n_bad == 0 && hits_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
